[design/chfx_pkg.sv]
// Shared constants, types and angle table for the compass heading block.
package chfx_pkg;

    // CORDIC iteration count, limited to the size of the angle table
    localparam int CORDIC_STEPS  = 16;
    localparam int ANG_TABLE_LEN = 24;
    localparam int STEPS = (CORDIC_STEPS > ANG_TABLE_LEN) ? ANG_TABLE_LEN : CORDIC_STEPS;

    localparam int RAW_W     = 16;
    localparam int GAIN_W    = 16;
    localparam int PROD_W    = 32;
    localparam int PRE_SHIFT = 24;
    // |product| <= 2^30, pre-scaled by 2^24, CORDIC growth below 2.4
    localparam int VEC_W     = 58;
    localparam int ANG_W     = 26;
    localparam int ATAN_W    = 22;
    localparam int FRAC_DEG  = 16;
    localparam int DEG_W     = 9;

    localparam logic signed [ANG_W-1:0] DEG_180 = ANG_W'(180 * 65536);
    localparam logic signed [ANG_W-1:0] DEG_360 = ANG_W'(360 * 65536);

    // atan(2^-i) in degrees, times 2^16, rounded
    localparam logic [ATAN_W-1:0] ANG_TAB [ANG_TABLE_LEN] = '{
        22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
        22'd58666,   22'd29335,   22'd14668,  22'd7334,   22'd3667,   22'd1833,
        22'd917,     22'd458,     22'd229,    22'd115,    22'd57,     22'd29,
        22'd14,      22'd7,       22'd4,      22'd2,      22'd1,      22'd0
    };

    localparam logic [DEG_W-1:0] HEAD_0   = 9'd0;
    localparam logic [DEG_W-1:0] HEAD_90  = 9'd90;
    localparam logic [DEG_W-1:0] HEAD_180 = 9'd180;
    localparam logic [DEG_W-1:0] HEAD_270 = 9'd270;

    // Configuration register map
    localparam int CFG_IDX_W = 8;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_X_GAIN = 8'd0,
        CFG_Y_GAIN = 8'd1
    } t_cfg_idx;

    localparam logic signed [GAIN_W-1:0] X_GAIN_RST = -16'sd1500;
    localparam logic signed [GAIN_W-1:0] Y_GAIN_RST = 16'sd1494;

    // Queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    // Result queue; deep enough to cover every item in the CORDIC pipe
    localparam int OUT_DEPTH = 2 ** $clog2(STEPS + 3);
    localparam int OUT_AW    = $clog2(OUT_DEPTH);
    localparam int CNT_W     = OUT_AW + 1;

    typedef struct packed {
        logic signed [PROD_W-1:0] px;
        logic signed [PROD_W-1:0] py;
        logic                     special;
        logic [DEG_W-1:0]         sp_deg;
    } t_work;

endpackage

[design/chfx_queue.sv]
// Short work queue between the front (scaling) and the back (CORDIC).
module chfx_queue import chfx_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_work i_item,
    output logic  o_full,
    output logic  o_empty,
    input  logic  i_pop,
    output t_work o_item
);

    t_work             r_mem [Q_DEPTH];
    logic [Q_AW-1:0]   r_wr, r_rd;
    logic [Q_AW:0]     r_cnt;
    logic              w_push, w_pop;

    assign o_full  = (r_cnt == (Q_AW+1)'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_item  = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (Q_AW+1)'(w_push) - (Q_AW+1)'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

[design/chfx_front.sv]
// Front: gain registers, input capture with axis scaling, special-case classification.
module chfx_front import chfx_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    output logic                   o_full,
    input  logic signed [RAW_W-1:0] i_raw_x,
    input  logic signed [RAW_W-1:0] i_raw_y,
    input  logic                   i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [GAIN_W-1:0]      i_cfg_data,
    output logic                   o_q_push,
    output t_work                  o_q_item,
    input  logic                   i_q_full
);

    logic signed [GAIN_W-1:0] r_x_gain, r_y_gain;
    logic signed [PROD_W-1:0] r_px, r_py;
    logic                     r_vld;
    logic                     w_accept;
    logic signed [PROD_W-1:0] w_px, w_py;

    assign o_full   = r_vld && i_q_full;
    assign w_accept = i_push && !o_full;
    assign o_q_push = r_vld && !i_q_full;

    assign w_px = PROD_W'(i_raw_x) * PROD_W'(r_x_gain);
    assign w_py = PROD_W'(i_raw_y) * PROD_W'(r_y_gain);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_gain <= X_GAIN_RST;
            r_y_gain <= Y_GAIN_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_X_GAIN: r_x_gain <= i_cfg_data;
                CFG_Y_GAIN: r_y_gain <= i_cfg_data;
                default:    ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (w_accept) begin
            r_vld <= 1'b1;
        end else if (o_q_push) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_px <= w_px;
            r_py <= w_py;
        end
    end

    // Vectors on an axis bypass the CORDIC
    always_comb begin
        o_q_item.px      = r_px;
        o_q_item.py      = r_py;
        o_q_item.special = (r_py == '0) || (r_px == '0);
        priority if (r_py == '0) begin
            o_q_item.sp_deg = r_px[PROD_W-1] ? HEAD_180 : HEAD_0;
        end else begin
            o_q_item.sp_deg = r_py[PROD_W-1] ? HEAD_90 : HEAD_270;
        end
    end

endmodule

[design/chfx_back.sv]
// Back: pipelined CORDIC vectoring, angle wrap and the result queue.
module chfx_back import chfx_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_empty,
    input  t_work            i_q_item,
    output logic             o_q_pop,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [DEG_W-1:0] o_heading_deg
);

    logic                     r_v   [0:STEPS];
    logic signed [VEC_W-1:0]  r_x   [0:STEPS];
    logic signed [VEC_W-1:0]  r_y   [0:STEPS];
    logic signed [ANG_W-1:0]  r_z   [0:STEPS];
    logic                     r_sp  [0:STEPS];
    logic [DEG_W-1:0]         r_spd [0:STEPS];

    logic [DEG_W-1:0]         r_omem [OUT_DEPTH];
    logic [OUT_AW-1:0]        r_owr, r_ord;
    logic [CNT_W-1:0]         r_ocnt;
    logic [CNT_W-1:0]         r_inflight;

    logic                     w_pop;
    logic                     w_neg;
    logic signed [VEC_W-1:0]  w_xs, w_ys;
    logic signed [ANG_W-1:0]  w_a;
    logic [DEG_W-1:0]         w_deg;

    // Issue only while the result queue has a slot reserved for the item
    assign o_q_pop = !i_q_empty && (r_inflight < CNT_W'(OUT_DEPTH));
    assign w_pop   = i_pop && !o_empty;

    // Pre-scale, negate y, and turn a vector in the left half-plane by 180 degrees into the right half-plane
    assign w_xs  = VEC_W'(i_q_item.px) <<< PRE_SHIFT;
    assign w_ys  = VEC_W'(i_q_item.py) <<< PRE_SHIFT;
    assign w_neg = i_q_item.px[PROD_W-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= o_q_pop;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x[0]   <= w_neg ? -w_xs : w_xs;
        r_y[0]   <= w_neg ? w_ys : -w_ys;
        r_z[0]   <= w_neg ? DEG_180 : '0;
        r_sp[0]  <= i_q_item.special;
        r_spd[0] <= i_q_item.sp_deg;
    end

    for (genvar g = 0; g < STEPS; g++) begin : g_step
        logic signed [VEC_W-1:0] w_dx, w_dy;
        logic signed [ANG_W-1:0] w_t;
        logic                    w_up;

        assign w_dx = r_y[g] >>> g;
        assign w_dy = r_x[g] >>> g;
        assign w_t  = $signed({{(ANG_W-ATAN_W){1'b0}}, ANG_TAB[g]});
        assign w_up = !r_y[g][VEC_W-1] && (r_y[g] != '0);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g+1] <= 1'b0;
            end else begin
                r_v[g+1] <= r_v[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_up) begin
                r_x[g+1] <= r_x[g] + w_dx;
                r_y[g+1] <= r_y[g] - w_dy;
                r_z[g+1] <= r_z[g] + w_t;
            end else begin
                r_x[g+1] <= r_x[g] - w_dx;
                r_y[g+1] <= r_y[g] + w_dy;
                r_z[g+1] <= r_z[g] - w_t;
            end
            r_sp[g+1]  <= r_sp[g];
            r_spd[g+1] <= r_spd[g];
        end
    end

    // Wrap into one turn and keep whole degrees
    assign w_a   = r_z[STEPS][ANG_W-1] ? (r_z[STEPS] + DEG_360) : r_z[STEPS];
    assign w_deg = r_sp[STEPS] ? r_spd[STEPS] : w_a[FRAC_DEG +: DEG_W];

    assign o_empty       = (r_ocnt == '0);
    assign o_heading_deg = r_omem[r_ord];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owr      <= '0;
            r_ord      <= '0;
            r_ocnt     <= '0;
            r_inflight <= '0;
        end else begin
            if (r_v[STEPS]) begin
                r_owr <= r_owr + 1'b1;
            end
            if (w_pop) begin
                r_ord <= r_ord + 1'b1;
            end
            r_ocnt     <= r_ocnt + CNT_W'(r_v[STEPS]) - CNT_W'(w_pop);
            r_inflight <= r_inflight + CNT_W'(o_q_pop) - CNT_W'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v[STEPS]) begin
            r_omem[r_owr] <= w_deg;
        end
    end

    a_inflight_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inflight <= CNT_W'(OUT_DEPTH))
        else $error("in-flight count exceeds result queue depth");

    a_queue_covered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ocnt <= r_inflight)
        else $error("result queue holds more than the reserved items");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[STEPS] |-> (r_ocnt < CNT_W'(OUT_DEPTH)))
        else $error("result written into a full queue");

    a_heading_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[STEPS] |-> (w_deg <= 9'd359))
        else $error("heading out of range");

endmodule

[design/compass_heading_from_xy.sv]
// Top level of the compass heading block: front, work queue and CORDIC back.
//
// Input side is a queue: present raw_x/raw_y with i_push; the transfer takes
// place at a clock edge with i_push high and o_full low. Result side is a
// queue too: while o_empty is low, o_heading_deg holds the oldest heading,
// and it is removed at an edge with i_pop high. Gains are written through the
// cfg channel (index 0 = X gain, 1 = Y gain, others dropped); o_cfg_ready is
// always high, and writes belong in idle periods.
// From input transfer to o_empty going low, the gain products register at
// the transfer edge, then the item passes through the work queue, the
// pre-rotation register and each CORDIC stage in turn, and goes into the
// result queue. Throughput: one item per cycle unless a full queue holds
// the flow, set by the fully pipelined CORDIC stages.
// The back issues an item only when a result-queue slot is reserved for it,
// so a receiver that stalls fills the result queue, then the work queue, and
// o_full rises; nothing is dropped. Synchronous reset empties both queues and
// the pipeline and reloads the gains with their default values.
module compass_heading_from_xy import chfx_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    output logic                    o_full,
    input  logic signed [RAW_W-1:0] i_raw_x,
    input  logic signed [RAW_W-1:0] i_raw_y,
    output logic                    o_empty,
    input  logic                    i_pop,
    output logic [DEG_W-1:0]        o_heading_deg,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [GAIN_W-1:0]       i_cfg_data
);

    logic  w_q_push, w_q_full, w_q_empty, w_q_pop;
    t_work w_q_in, w_q_out;

    assign o_cfg_ready = 1'b1;

    chfx_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_push),
        .o_full      (o_full),
        .i_raw_x     (i_raw_x),
        .i_raw_y     (i_raw_y),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_q_push    (w_q_push),
        .o_q_item    (w_q_in),
        .i_q_full    (w_q_full)
    );

    chfx_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_item  (w_q_in),
        .o_full  (w_q_full),
        .o_empty (w_q_empty),
        .i_pop   (w_q_pop),
        .o_item  (w_q_out)
    );

    chfx_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_empty     (w_q_empty),
        .i_q_item      (w_q_out),
        .o_q_pop       (w_q_pop),
        .i_pop         (i_pop),
        .o_empty       (o_empty),
        .o_heading_deg (o_heading_deg)
    );

endmodule

[tb/sv/compass_heading_from_xy_tb.sv]
// Self-checking testbench for the compass heading block: queue-style drive and bit-exact prediction.
`timescale 1ns / 100ps

import chfx_pkg::*;

class heading_tracker;
    logic signed [GAIN_W-1:0] x_gain;
    logic signed [GAIN_W-1:0] y_gain;
    logic [DEG_W-1:0]         headings_due[$];
    int                       mismatches;

    function new();
        x_gain     = X_GAIN_RST;
        y_gain     = Y_GAIN_RST;
        mismatches = 0;
    endfunction

    function void write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] data);
        unique case (idx)
            CFG_X_GAIN: x_gain = data;
            CFG_Y_GAIN: y_gain = data;
            default: ;
        endcase
    endfunction

    // Calibrated products, then CORDIC vectoring on (px, -py) scaled by 2^24.
    function logic [DEG_W-1:0] heading_for(input logic signed [RAW_W-1:0] rx,
                                           input logic signed [RAW_W-1:0] ry);
        longint px, py, xv, yv, dx, dy, ang, full_turn, deg;
        px = longint'(rx) * longint'(x_gain);
        py = longint'(ry) * longint'(y_gain);
        if (py == 0)
            return (px < 0) ? HEAD_180 : HEAD_0;
        if (px == 0)
            return (py < 0) ? HEAD_90 : HEAD_270;
        full_turn = longint'(DEG_360);
        xv  = px <<< PRE_SHIFT;
        yv  = (-py) <<< PRE_SHIFT;
        ang = 0;
        if (xv < 0) begin
            xv  = -xv;
            yv  = -yv;
            ang = longint'(DEG_180);
        end
        for (int i = 0; i < STEPS; i++) begin
            dx = yv >>> i;
            dy = xv >>> i;
            if (yv > 0) begin
                xv  = xv + dx;
                yv  = yv - dy;
                ang = ang + longint'(ANG_TAB[i]);
            end else begin
                xv  = xv - dx;
                yv  = yv + dy;
                ang = ang - longint'(ANG_TAB[i]);
            end
        end
        while (ang < 0)
            ang = ang + full_turn;
        while (ang >= full_turn)
            ang = ang - full_turn;
        deg = ang >>> FRAC_DEG;
        if (deg > 359)
            deg = 359;
        return deg[DEG_W-1:0];
    endfunction

    function void note_sample(input logic signed [RAW_W-1:0] rx,
                              input logic signed [RAW_W-1:0] ry);
        headings_due.push_back(heading_for(rx, ry));
    endfunction

    function void check_heading(input logic [DEG_W-1:0] actual);
        logic [DEG_W-1:0] due;
        if (headings_due.size() == 0) begin
            $display("%0t unexpected heading: expected none, actual %0d", $time, actual);
            mismatches++;
        end else begin
            due = headings_due.pop_front();
            if (due !== actual) begin
                $display("%0t heading mismatch: expected %0d, actual %0d", $time, due, actual);
                mismatches++;
            end
        end
    endfunction

    function int pending();
        return headings_due.size();
    endfunction

    function bit all_clear();
        if (headings_due.size() != 0)
            $display("%0t headings never delivered: expected %0d more, actual 0",
                     $time, headings_due.size());
        return (mismatches == 0) && (headings_due.size() == 0);
    endfunction
endclass

module compass_heading_from_xy_tb;

    localparam int WATCHDOG_LIMIT   = 1000;
    localparam int SETTLE_CYCLES    = 2 * (STEPS + 3);
    localparam int N_DIRECTED       = 23;
    localparam int N_FIXED_PHASES   = 9;
    localparam int N_PHASES         = 11;
    localparam int ITEMS_PER_PHASE  = 90;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED_MAX = '1;

    localparam logic signed [RAW_W-1:0] DIR_X [N_DIRECTED] = '{
        16'sd0, 16'sd100, -16'sd100, 16'sd0, 16'sd0, 16'sd32767, -16'sd32768, 16'sd0,
        16'sd0, 16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768, 16'sd1, -16'sd1,
        16'sd1, -16'sd1, -16'sd1, 16'sd0, 16'sd1000, 16'sd12345, -16'sd32768, -16'sd1
    };
    localparam logic signed [RAW_W-1:0] DIR_Y [N_DIRECTED] = '{
        16'sd0, 16'sd0, 16'sd0, 16'sd100, -16'sd100, 16'sd0, 16'sd0, 16'sd32767,
        -16'sd32768, 16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767, 16'sd1, -16'sd1,
        -16'sd1, 16'sd1, 16'sd0, -16'sd1, -16'sd1004, -16'sd6789, -16'sd1, -16'sd32768
    };
    localparam logic signed [GAIN_W-1:0] PHASE_GX [N_FIXED_PHASES] = '{
        -16'sd1500, 16'sd32767, -16'sd32768, 16'sd1, 16'sd0, -16'sd700, 16'sd0,
        -16'sd32768, 16'sd12000
    };
    localparam logic signed [GAIN_W-1:0] PHASE_GY [N_FIXED_PHASES] = '{
        16'sd1494, 16'sd32767, -16'sd32768, -16'sd1, 16'sd1000, 16'sd0, 16'sd0,
        16'sd32767, -16'sd9000
    };

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_push;
    logic                    o_full;
    logic signed [RAW_W-1:0] i_raw_x;
    logic signed [RAW_W-1:0] i_raw_y;
    logic                    o_empty;
    logic                    i_pop;
    logic [DEG_W-1:0]        o_heading_deg;
    logic                    i_cfg_valid;
    logic                    o_cfg_ready;
    logic [CFG_IDX_W-1:0]    i_cfg_index;
    logic [GAIN_W-1:0]       i_cfg_data;

    heading_tracker tracker;
    int             burst_left;

    compass_heading_from_xy i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (i_push),
        .o_full        (o_full),
        .i_raw_x       (i_raw_x),
        .i_raw_y       (i_raw_y),
        .o_empty       (o_empty),
        .i_pop         (i_pop),
        .o_heading_deg (o_heading_deg),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic signed [RAW_W-1:0] extreme_value();
        unique case ($urandom_range(0, 5))
            0: return -16'sd32768;
            1: return -16'sd32767;
            2: return -16'sd1;
            3: return 16'sd0;
            4: return 16'sd1;
            default: return 16'sd32767;
        endcase
    endfunction

    task automatic rand_sample(output logic signed [RAW_W-1:0] x,
                               output logic signed [RAW_W-1:0] y);
        int sel;
        int v;
        sel = $urandom_range(0, 99);
        x = RAW_W'($urandom);
        y = RAW_W'($urandom);
        if (sel >= 60 && sel < 70) begin
            // one axis dead on zero
            if ($urandom_range(0, 1))
                x = '0;
            else
                y = '0;
        end else if (sel < 80 && sel >= 70) begin
            v = $urandom_range(0, 8);
            x = RAW_W'(v - 4);
            v = $urandom_range(0, 8);
            y = RAW_W'(v - 4);
        end else if (sel < 90 && sel >= 80) begin
            x = extreme_value();
            y = extreme_value();
        end else if (sel >= 90) begin
            // near the diagonals
            v = $urandom_range(0, 2);
            y = $urandom_range(0, 1) ? x : -x;
            y = y + RAW_W'(v - 1);
        end
    endtask

    task automatic send_sample(input logic signed [RAW_W-1:0] x,
                               input logic signed [RAW_W-1:0] y);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 40);
            if (gap > 0) begin
                i_push <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_push  <= 1'b1;
        i_raw_x <= x;
        i_raw_y <= y;
        do @(posedge i_clk); while (o_full);
        tracker.note_sample(x, y);
    endtask

    // Hold the sender until every heading in flight has been popped.
    task automatic wait_drained();
        i_push     <= 1'b0;
        burst_left = 0;
        while (tracker.pending() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_gains(input logic signed [GAIN_W-1:0] gx,
                               input logic signed [GAIN_W-1:0] gy);
        logic [CFG_IDX_W-1:0] idx [3];
        logic [GAIN_W-1:0]    data [3];
        idx[0]  = CFG_X_GAIN;
        data[0] = gx;
        idx[1]  = CFG_Y_GAIN;
        data[1] = gy;
        // unmapped index; must leave both gains alone
        idx[2]  = $urandom_range(0, 1) ? CFG_IDX_UNUSED_MAX : CFG_IDX_W'($urandom_range(2, 255));
        data[2] = GAIN_W'($urandom);
        for (int k = 0; k < 3; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx[k];
            i_cfg_data  <= data[k];
            do @(posedge i_clk); while (!o_cfg_ready);
            tracker.write_reg(idx[k], data[k]);
        end
        i_cfg_valid <= 1'b0;
    endtask

    // Receiver: pops on its own pattern of free-running, random and long stalls.
    initial begin
        int mode;
        int span;
        i_pop <= 1'b0;
        mode  = 0;
        span  = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && i_pop && !o_empty)
                tracker.check_heading(o_heading_deg);
            if (span == 0) begin
                mode = $urandom_range(0, 2);
                span = $urandom_range(20, 200);
            end
            span--;
            unique case (mode)
                0: i_pop <= 1'b1;
                1: i_pop <= $urandom_range(0, 1);
                default: i_pop <= (span % 32) < 4;
            endcase
        end
    end

    initial begin
        int idle;
        idle = 0;
        while (idle < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_push && !o_full) || (i_pop && !o_empty) || (i_cfg_valid && o_cfg_ready))
                idle = 0;
            else
                idle++;
        end
        $display("compass_heading_from_xy: mismatch");
        $finish;
    end

    initial begin
        logic signed [RAW_W-1:0]  x;
        logic signed [RAW_W-1:0]  y;
        logic signed [GAIN_W-1:0] gx;
        logic signed [GAIN_W-1:0] gy;
        tracker     = new();
        burst_left  = 0;
        i_rst_n     <= 1'b0;
        i_push      <= 1'b0;
        i_raw_x     <= '0;
        i_raw_y     <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_X_GAIN;
        i_cfg_data  <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // axes, quadrants and extremes at the reset gains
        for (int n = 0; n < N_DIRECTED; n++)
            send_sample(DIR_X[n], DIR_Y[n]);
        wait_drained();

        for (int p = 0; p < N_PHASES; p++) begin
            if (p < N_FIXED_PHASES) begin
                gx = PHASE_GX[p];
                gy = PHASE_GY[p];
            end else begin
                gx = GAIN_W'($urandom);
                gy = GAIN_W'($urandom);
            end
            write_gains(gx, gy);
            repeat (ITEMS_PER_PHASE) begin
                rand_sample(x, y);
                send_sample(x, y);
            end
            wait_drained();
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (tracker.all_clear())
            $display("compass_heading_from_xy: match");
        else
            $display("compass_heading_from_xy: mismatch");
        $finish;
    end

endmodule
